// File: rtl/core/desd_pkg.sv
// Package for the DES decryption core: S-box/P tables, the key schedule
// and the initial and final permutations as functions.
// Used by desd_round and des_block_decrypt_core; depends on nothing.
package desd_pkg;

    localparam int NumRounds = 16;

    typedef logic [31:0] word_t;
    typedef logic [63:0] block_t;
    typedef word_t       sched_t [32];

    typedef word_t sbox_row_t [64];

    localparam sbox_row_t SBOX_P0 = '{
        32'h01010400,32'h00000000,32'h00010000,32'h01010404,32'h01010004,32'h00010404,32'h00000004,32'h00010000,
        32'h00000400,32'h01010400,32'h01010404,32'h00000400,32'h01000404,32'h01010004,32'h01000000,32'h00000004,
        32'h00000404,32'h01000400,32'h01000400,32'h00010400,32'h00010400,32'h01010000,32'h01010000,32'h01000404,
        32'h00010004,32'h01000004,32'h01000004,32'h00010004,32'h00000000,32'h00000404,32'h00010404,32'h01000000,
        32'h00010000,32'h01010404,32'h00000004,32'h01010000,32'h01010400,32'h01000000,32'h01000000,32'h00000400,
        32'h01010004,32'h00010000,32'h00010400,32'h01000004,32'h00000400,32'h00000004,32'h01000404,32'h00010404,
        32'h01010404,32'h00010004,32'h01010000,32'h01000404,32'h01000004,32'h00000404,32'h00010404,32'h01010400,
        32'h00000404,32'h01000400,32'h01000400,32'h00000000,32'h00010004,32'h00010400,32'h00000000,32'h01010004};
    localparam sbox_row_t SBOX_P1 = '{
        32'h80108020,32'h80008000,32'h00008000,32'h00108020,32'h00100000,32'h00000020,32'h80100020,32'h80008020,
        32'h80000020,32'h80108020,32'h80108000,32'h80000000,32'h80008000,32'h00100000,32'h00000020,32'h80100020,
        32'h00108000,32'h00100020,32'h80008020,32'h00000000,32'h80000000,32'h00008000,32'h00108020,32'h80100000,
        32'h00100020,32'h80000020,32'h00000000,32'h00108000,32'h00008020,32'h80108000,32'h80100000,32'h00008020,
        32'h00000000,32'h00108020,32'h80100020,32'h00100000,32'h80008020,32'h80100000,32'h80108000,32'h00008000,
        32'h80100000,32'h80008000,32'h00000020,32'h80108020,32'h00108020,32'h00000020,32'h00008000,32'h80000000,
        32'h00008020,32'h80108000,32'h00100000,32'h80000020,32'h00100020,32'h80008020,32'h80000020,32'h00100020,
        32'h00108000,32'h00000000,32'h80008000,32'h00008020,32'h80000000,32'h80100020,32'h80108020,32'h00108000};
    localparam sbox_row_t SBOX_P2 = '{
        32'h00000208,32'h08020200,32'h00000000,32'h08020008,32'h08000200,32'h00000000,32'h00020208,32'h08000200,
        32'h00020008,32'h08000008,32'h08000008,32'h00020000,32'h08020208,32'h00020008,32'h08020000,32'h00000208,
        32'h08000000,32'h00000008,32'h08020200,32'h00000200,32'h00020200,32'h08020000,32'h08020008,32'h00020208,
        32'h08000208,32'h00020200,32'h00020000,32'h08000208,32'h00000008,32'h08020208,32'h00000200,32'h08000000,
        32'h08020200,32'h08000000,32'h00020008,32'h00000208,32'h00020000,32'h08020200,32'h08000200,32'h00000000,
        32'h00000200,32'h00020008,32'h08020208,32'h08000200,32'h08000008,32'h00000200,32'h00000000,32'h08020008,
        32'h08000208,32'h00020000,32'h08000000,32'h08020208,32'h00000008,32'h00020208,32'h00020200,32'h08000008,
        32'h08020000,32'h08000208,32'h00000208,32'h08020000,32'h00020208,32'h00000008,32'h08020008,32'h00020200};
    localparam sbox_row_t SBOX_P3 = '{
        32'h00802001,32'h00002081,32'h00002081,32'h00000080,32'h00802080,32'h00800081,32'h00800001,32'h00002001,
        32'h00000000,32'h00802000,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00800080,32'h00800001,
        32'h00000001,32'h00002000,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002001,32'h00002080,
        32'h00800081,32'h00000001,32'h00002080,32'h00800080,32'h00002000,32'h00802080,32'h00802081,32'h00000081,
        32'h00800080,32'h00800001,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00000000,32'h00802000,
        32'h00002080,32'h00800080,32'h00800081,32'h00000001,32'h00802001,32'h00002081,32'h00002081,32'h00000080,
        32'h00802081,32'h00000081,32'h00000001,32'h00002000,32'h00800001,32'h00002001,32'h00802080,32'h00800081,
        32'h00002001,32'h00002080,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002000,32'h00802080};
    localparam sbox_row_t SBOX_P4 = '{
        32'h00000100,32'h02080100,32'h02080000,32'h42000100,32'h00080000,32'h00000100,32'h40000000,32'h02080000,
        32'h40080100,32'h00080000,32'h02000100,32'h40080100,32'h42000100,32'h42080000,32'h00080100,32'h40000000,
        32'h02000000,32'h40080000,32'h40080000,32'h00000000,32'h40000100,32'h42080100,32'h42080100,32'h02000100,
        32'h42080000,32'h40000100,32'h00000000,32'h42000000,32'h02080100,32'h02000000,32'h42000000,32'h00080100,
        32'h00080000,32'h42000100,32'h00000100,32'h02000000,32'h40000000,32'h02080000,32'h42000100,32'h40080100,
        32'h02000100,32'h40000000,32'h42080000,32'h02080100,32'h40080100,32'h00000100,32'h02000000,32'h42080000,
        32'h42080100,32'h00080100,32'h42000000,32'h42080100,32'h02080000,32'h00000000,32'h40080000,32'h42000000,
        32'h00080100,32'h02000100,32'h40000100,32'h00080000,32'h00000000,32'h40080000,32'h02080100,32'h40000100};
    localparam sbox_row_t SBOX_P5 = '{
        32'h20000010,32'h20400000,32'h00004000,32'h20404010,32'h20400000,32'h00000010,32'h20404010,32'h00400000,
        32'h20004000,32'h00404010,32'h00400000,32'h20000010,32'h00400010,32'h20004000,32'h20000000,32'h00004010,
        32'h00000000,32'h00400010,32'h20004010,32'h00004000,32'h00404000,32'h20004010,32'h00000010,32'h20400010,
        32'h20400010,32'h00000000,32'h00404010,32'h20404000,32'h00004010,32'h00404000,32'h20404000,32'h20000000,
        32'h20004000,32'h00000010,32'h20400010,32'h00404000,32'h20404010,32'h00400000,32'h00004010,32'h20000010,
        32'h00400000,32'h20004000,32'h20000000,32'h00004010,32'h20000010,32'h20404010,32'h00404000,32'h20400000,
        32'h00404010,32'h20404000,32'h00000000,32'h20400010,32'h00000010,32'h00004000,32'h20400000,32'h00404010,
        32'h00004000,32'h00400010,32'h20004010,32'h00000000,32'h20404000,32'h20000000,32'h00400010,32'h20004010};
    localparam sbox_row_t SBOX_P6 = '{
        32'h00200000,32'h04200002,32'h04000802,32'h00000000,32'h00000800,32'h04000802,32'h00200802,32'h04200800,
        32'h04200802,32'h00200000,32'h00000000,32'h04000002,32'h00000002,32'h04000000,32'h04200002,32'h00000802,
        32'h04000800,32'h00200802,32'h00200002,32'h04000800,32'h04000002,32'h04200000,32'h04200800,32'h00200002,
        32'h04200000,32'h00000800,32'h00000802,32'h04200802,32'h00200800,32'h00000002,32'h04000000,32'h00200800,
        32'h04000000,32'h00200800,32'h00200000,32'h04000802,32'h04000802,32'h04200002,32'h04200002,32'h00000002,
        32'h00200002,32'h04000000,32'h04000800,32'h00200000,32'h04200800,32'h00000802,32'h00200802,32'h04200800,
        32'h00000802,32'h04000002,32'h04200802,32'h04200000,32'h00200800,32'h00000000,32'h00000002,32'h04200802,
        32'h00000000,32'h00200802,32'h04200000,32'h00000800,32'h04000002,32'h04000800,32'h00000800,32'h00200002};
    localparam sbox_row_t SBOX_P7 = '{
        32'h10001040,32'h00001000,32'h00040000,32'h10041040,32'h10000000,32'h10001040,32'h00000040,32'h10000000,
        32'h00040040,32'h10040000,32'h10041040,32'h00041000,32'h10041000,32'h00041040,32'h00001000,32'h00000040,
        32'h10040000,32'h10000040,32'h10001000,32'h00001040,32'h00041000,32'h00040040,32'h10040040,32'h10041000,
        32'h00001040,32'h00000000,32'h00000000,32'h10040040,32'h10000040,32'h10001000,32'h00041040,32'h00040000,
        32'h00041040,32'h00040000,32'h10041000,32'h00001000,32'h00000040,32'h10040040,32'h00001000,32'h00041040,
        32'h10001000,32'h00000040,32'h10000040,32'h10040000,32'h10040040,32'h10000000,32'h00040000,32'h10001040,
        32'h00000000,32'h10041040,32'h00040040,32'h10000040,32'h10040000,32'h10001000,32'h10001040,32'h00000000,
        32'h10041040,32'h00041000,32'h00041000,32'h00001040,32'h00001040,32'h00040040,32'h10000000,32'h10041000};

    function automatic word_t rotr32(input word_t a, input int n);
        return (a >> n) | (a << (32 - n));
    endfunction

    function automatic word_t rotl28(input word_t a, input int n);
        return ((a << n) | (a >> (28 - n))) & 32'h0FFFFFFF;
    endfunction

    // Returns {new a, new b} after the masked bit exchange.
    function automatic logic [63:0] exch(input word_t a, input word_t b,
                                         input int s, input word_t m);
        word_t t;
        t = ((a >> s) ^ b) & m;
        return {a ^ (t << s), b ^ t};
    endfunction

    function automatic sched_t key_schedule(input block_t key);
        word_t c, d, t;
        logic [63:0] p;
        sched_t rk;
        int n;
        c = key[63:32];
        d = key[31:0];
        p = exch(c, d, 4, 32'h0F0F0F0F);  c = p[63:32]; d = p[31:0];
        p = exch(d, c, 16, 32'h0000FFFF); d = p[63:32]; c = p[31:0];
        p = exch(c, d, 2, 32'h33333333);  c = p[63:32]; d = p[31:0];
        p = exch(d, c, 16, 32'h0000FFFF); d = p[63:32]; c = p[31:0];
        p = exch(c, d, 1, 32'h55555555);  c = p[63:32]; d = p[31:0];
        p = exch(d, c, 8, 32'h00FF00FF);  d = p[63:32]; c = p[31:0];
        p = exch(c, d, 1, 32'h55555555);  c = p[63:32]; d = p[31:0];
        t = (c << 8) | ((d >> 20) & 32'h000000F0);
        c = ((d << 20) & 32'h0FF00000) | ((d << 4) & 32'h000FF000) |
            ((d >> 12) & 32'h00000FF0) | ((d >> 28) & 32'h0000000F);
        d = t >> 4;
        for (int r = 0; r < NumRounds; r++) begin
            n = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
            c = rotl28(c, n);
            d = rotl28(d, n);
            rk[2*r] =
                ((c << 4) & 32'h24000000) | ((c << 28) & 32'h10000000) |
                ((c << 14) & 32'h08000000) | ((c << 18) & 32'h02080000) |
                ((c << 6) & 32'h01000000) | ((c << 9) & 32'h00200000) |
                ((c >> 1) & 32'h00100000) | ((c << 10) & 32'h00040000) |
                ((c << 2) & 32'h00020000) | ((c >> 10) & 32'h00010000) |
                ((d >> 13) & 32'h00002000) | ((d >> 4) & 32'h00001000) |
                ((d << 6) & 32'h00000800) | ((d >> 1) & 32'h00000400) |
                ((d >> 14) & 32'h00000200) | (d & 32'h00000100) |
                ((d >> 5) & 32'h00000020) | ((d >> 10) & 32'h00000010) |
                ((d >> 3) & 32'h00000008) | ((d >> 18) & 32'h00000004) |
                ((d >> 26) & 32'h00000002) | ((d >> 24) & 32'h00000001);
            rk[2*r+1] =
                ((c << 15) & 32'h20000000) | ((c << 17) & 32'h10000000) |
                ((c << 10) & 32'h08000000) | ((c << 22) & 32'h04000000) |
                ((c >> 2) & 32'h02000000) | ((c << 1) & 32'h01000000) |
                ((c << 16) & 32'h00200000) | ((c << 11) & 32'h00100000) |
                ((c << 3) & 32'h00080000) | ((c >> 6) & 32'h00040000) |
                ((c << 15) & 32'h00020000) | ((c >> 4) & 32'h00010000) |
                ((d >> 2) & 32'h00002000) | ((d << 8) & 32'h00001000) |
                ((d >> 14) & 32'h00000808) | ((d >> 9) & 32'h00000400) |
                (d & 32'h00000200) | ((d << 7) & 32'h00000100) |
                ((d >> 7) & 32'h00000020) | ((d >> 3) & 32'h00000011) |
                ((d << 2) & 32'h00000004) | ((d >> 21) & 32'h00000002);
        end
        return rk;
    endfunction

    // Initial permutation; returns {hi, lo}, both pre-rotated left by one.
    function automatic block_t init_perm(input block_t blk);
        word_t hi, lo;
        logic [63:0] p;
        hi = blk[63:32];
        lo = blk[31:0];
        p = exch(hi, lo, 4, 32'h0F0F0F0F);  hi = p[63:32]; lo = p[31:0];
        p = exch(hi, lo, 16, 32'h0000FFFF); hi = p[63:32]; lo = p[31:0];
        p = exch(lo, hi, 2, 32'h33333333);  lo = p[63:32]; hi = p[31:0];
        p = exch(lo, hi, 8, 32'h00FF00FF);  lo = p[63:32]; hi = p[31:0];
        p = exch(hi, lo, 1, 32'h55555555);  hi = p[63:32]; lo = p[31:0];
        return {rotr32(hi, 31), rotr32(lo, 31)};
    endfunction

    // Final permutation of {hi, lo} after the last round.
    function automatic block_t final_perm(input block_t st);
        word_t hi, lo;
        logic [63:0] p;
        hi = rotr32(st[63:32], 1);
        lo = rotr32(st[31:0], 1);
        p = exch(lo, hi, 1, 32'h55555555);  lo = p[63:32]; hi = p[31:0];
        p = exch(hi, lo, 8, 32'h00FF00FF);  hi = p[63:32]; lo = p[31:0];
        p = exch(hi, lo, 2, 32'h33333333);  hi = p[63:32]; lo = p[31:0];
        p = exch(lo, hi, 16, 32'h0000FFFF); lo = p[63:32]; hi = p[31:0];
        p = exch(lo, hi, 4, 32'h0F0F0F0F);  lo = p[63:32]; hi = p[31:0];
        return {lo, hi};
    endfunction

endpackage

// File: rtl/core/desd_round.sv
// One Feistel round of the DES decryption pipeline with its stage register.
// Depends on desd_pkg for the merged S-box/P tables.
module desd_round (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  desd_pkg::block_t   in_state,
    input  desd_pkg::word_t    key_even,
    input  desd_pkg::word_t    key_odd,
    output logic               out_valid,
    output desd_pkg::block_t   out_state
);

    desd_pkg::word_t hi, lo, ta, tb, f_val;
    logic             valid_reg;
    desd_pkg::block_t state_reg;

    always_comb begin
        hi = in_state[63:32];
        lo = in_state[31:0];
        ta = lo ^ key_even;
        tb = desd_pkg::rotr32(lo, 4) ^ key_odd;
        f_val = desd_pkg::SBOX_P1[ta[29:24]] ^ desd_pkg::SBOX_P3[ta[21:16]] ^
                desd_pkg::SBOX_P5[ta[13:8]]  ^ desd_pkg::SBOX_P7[ta[5:0]] ^
                desd_pkg::SBOX_P0[tb[29:24]] ^ desd_pkg::SBOX_P2[tb[21:16]] ^
                desd_pkg::SBOX_P4[tb[13:8]]  ^ desd_pkg::SBOX_P6[tb[5:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            state_reg <= {lo, hi ^ f_val};
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// File: rtl/core/des_block_decrypt_core.sv
// Top level of the DES decryption core: key schedule register, input
// permutation stage, sixteen round stages and the output stage.
// Depends on desd_pkg and desd_round.
// Registers from input transaction to result: permutation stage, sixteen round
// stages, output register. Throughput: one block per cycle unless the output stalls.
// The whole pipeline advances together; a stalled output holds all stages.
// Reset clears the valid bits and loads the schedule of an all-zero key.
module des_block_decrypt_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // cipher_block[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // plain_block[63:0]
);

    localparam int NumRounds = desd_pkg::NumRounds;

    desd_pkg::sched_t sched_reg;
    logic             ip_valid_reg;
    desd_pkg::block_t ip_state_reg;
    logic             out_valid_reg;
    desd_pkg::block_t out_data_reg;
    logic             advance;
    logic             stg_valid [NumRounds+1];
    desd_pkg::block_t stg_state [NumRounds+1];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_reg <= desd_pkg::key_schedule('0);
        end else if (cfg_wr_en) begin
            sched_reg <= desd_pkg::key_schedule(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            ip_valid_reg  <= s_tvalid;
            out_valid_reg <= stg_valid[NumRounds];
        end
        if (advance) begin
            ip_state_reg <= desd_pkg::init_perm(s_tdata);
            out_data_reg <= desd_pkg::final_perm(stg_state[NumRounds]);
        end
    end

    assign stg_valid[0] = ip_valid_reg;
    assign stg_state[0] = ip_state_reg;

    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        desd_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (stg_valid[r]),
            .in_state  (stg_state[r]),
            .key_even  (sched_reg[30 - 2*r]),
            .key_odd   (sched_reg[31 - 2*r]),
            .out_valid (stg_valid[r+1]),
            .out_state (stg_state[r+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sim/des_block_decrypt_core_tb.sv
// Testbench for des_block_decrypt_core: drives ciphertext blocks under several keys and
// idle patterns and checks each plaintext against a self-contained DES decryption model.
// Depends on desd_pkg (types only) and the core RTL.
`timescale 1ns / 100ps

module des_block_decrypt_core_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [63:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    des_block_decrypt_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    localparam int PipeDepth = 18;

    // Standard DES tables; permutation entries are 1-based bit positions counted from the MSB.
    localparam int IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6,
        64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam int FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
        37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam int E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam int P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam int PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam int PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    localparam int SHIFT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam int SBOX_TAB [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    logic [47:0]      subkeys [16];
    desd_pkg::block_t plain_q [$];
    int               err_cnt;
    int               rx_cnt;
    int               tx_cnt;
    int               key_cnt;
    int               src_idle_pct;
    int               snk_stall_pct;

    function automatic void expand_key(input desd_pkg::block_t key);
        logic [55:0] cd;
        logic [27:0] c, d;
        logic [55:0] joined;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TAB[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++) begin
            for (int s = 0; s < SHIFT_TAB[r]; s++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            joined = {c, d};
            for (int i = 0; i < 48; i++) subkeys[r][47-i] = joined[56-PC2_TAB[i]];
        end
    endfunction

    function automatic desd_pkg::block_t des_decrypt(input desd_pkg::block_t blk);
        desd_pkg::block_t perm, pre;
        desd_pkg::word_t  l, r, f, s_out, tmp;
        logic [47:0]      x;
        logic [5:0]       six;
        for (int i = 0; i < 64; i++) perm[63-i] = blk[64-IP_TAB[i]];
        l = perm[63:32];
        r = perm[31:0];
        for (int rnd = 15; rnd >= 0; rnd--) begin
            for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
            x = x ^ subkeys[rnd];
            for (int b = 0; b < 8; b++) begin
                six = x[47-6*b -: 6];
                s_out[31-4*b -: 4] = 4'(SBOX_TAB[b][{six[5], six[0], six[4:1]}]);
            end
            for (int i = 0; i < 32; i++) f[31-i] = s_out[32-P_TAB[i]];
            tmp = r;
            r = l ^ f;
            l = tmp;
        end
        pre = {r, l};
        for (int i = 0; i < 64; i++) perm[63-i] = pre[64-FP_TAB[i]];
        return perm;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_cnt++;
            if (plain_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transaction, actual %h", $time, m_tdata);
            end else begin
                desd_pkg::block_t want;
                want = plain_q.pop_front();
                if (m_tdata !== want) begin
                    err_cnt++;
                    $display("%0t: plain_block mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                end
            end
        end
    end

    task automatic send_block(input desd_pkg::block_t blk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        plain_q.push_back(des_decrypt(blk));
        tx_cnt++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (plain_q.size() != 0) @(negedge aclk);
        repeat (PipeDepth + 4) @(negedge aclk);
    endtask

    task automatic load_key(input desd_pkg::block_t key);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= key;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        expand_key(key);
        key_cnt++;
    endtask

    task automatic test_reset_key;
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h8CA6_4DE9_C1B1_23A7);
    endtask

    task automatic test_known_vectors;
        load_key(64'h1334_5779_9BBC_DFF1);
        send_block(64'h85E8_1354_0F0A_B405);
        load_key(64'h0123_4567_89AB_CDEF);
        send_block(64'h8000_0000_0000_0000);
        send_block(64'h0000_0000_0000_0001);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_extreme_keys;
        load_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        load_key(64'h0101_0101_0101_0101);
        send_block(64'h0123_4567_89AB_CDEF);
        load_key(64'h0000_0000_0000_0000);
        send_block(64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        load_key({$urandom, $urandom});
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            send_block({$urandom, $urandom});
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        err_cnt = 0; rx_cnt = 0; tx_cnt = 0; key_cnt = 0;
        src_idle_pct = 0; snk_stall_pct = 0;
        expand_key(64'h0);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_key();
        test_known_vectors();
        test_extreme_keys();
        test_random_phase(0, 0, 100);
        test_random_phase(69, 0, 100);
        test_random_phase(0, 69, 100);
        test_random_phase(12, 12, 100);
        drain();

        $display("Decrypted %0d blocks under %0d key writes, %0d results checked.",
                 tx_cnt, key_cnt, rx_cnt);
        $display("Phases covered free flow, sender gaps, receiver stalls and both mixed.");
        if (err_cnt == 0 && plain_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/desd_pkg.sv
rtl/core/desd_round.sv
rtl/core/des_block_decrypt_core.sv
sim/des_block_decrypt_core_tb.sv
